// File: design/trimming_priority_switch_queue_unit_assert.svh
// Assertion macros for the trimming priority switch queue unit.
// Used by the RTL module that carries concurrent assertions.
`ifndef TRIMMING_PRIORITY_SWITCH_QUEUE_UNIT_ASSERT_SVH
`define TRIMMING_PRIORITY_SWITCH_QUEUE_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define TPSQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define TPSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/tpsq_pkg.sv
// Shared types and codes for the trimming priority switch queue unit.
// No dependencies.
package tpsq_pkg;

   localparam int NUM_CLASSES = 5;

   // Push outcome codes
   localparam logic [2:0] OUT_CTL_QUEUED = 3'd0;
   localparam logic [2:0] OUT_HDR_QUEUED = 3'd1;
   localparam logic [2:0] OUT_DATA_QUEUED = 3'd2;
   localparam logic [2:0] OUT_TRIMMED = 3'd3;
   localparam logic [2:0] OUT_DROPPED = 3'd4;
   localparam logic [2:0] OUT_BAD_PRIO = 3'd5;
   localparam logic [2:0] OUT_CTL_OVERFLOW = 3'd6;

   // Pop sources
   localparam logic [1:0] SRC_CONTROL = 2'd0;
   localparam logic [1:0] SRC_HEADER = 2'd1;
   localparam logic [1:0] SRC_DATA = 2'd2;

   // Register indexes
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_PERIOD = 1'b1;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } state_type;

   // Memory access plan handed from the controller to the storage block
   typedef struct packed {
      logic       ctl_wr;
      logic       hdr_wr;
      logic       dat_wr;
   } mem_cmd_type;

endpackage

// File: design/tpsq_store.sv
// Descriptor memories of the queue unit: control, header and class stores.
// Depends on tpsq_pkg. Synchronous memories, registered read.
module tpsq_store #(
   parameter int DATA_DEPTH    = 64,
   parameter int HEADER_DEPTH  = 64,
   parameter int CONTROL_DEPTH = 16,
   parameter int DESC_WIDTH    = 16,
   parameter int CW = $clog2(CONTROL_DEPTH),
   parameter int HW = $clog2(HEADER_DEPTH),
   parameter int KW = $clog2(5 * DATA_DEPTH)
) (
   input  logic                   clock,
   input  tpsq_pkg::mem_cmd_type  cmd,
   input  logic [DESC_WIDTH-1:0]  wr_desc,
   input  logic                   wr_trim,
   input  logic [CW-1:0]          ctl_waddr,
   input  logic [HW-1:0]          hdr_waddr,
   input  logic [KW-1:0]          dat_waddr,
   input  logic [CW-1:0]          ctl_raddr,
   input  logic [HW-1:0]          hdr_raddr,
   input  logic [KW-1:0]          dat_raddr,
   output logic [DESC_WIDTH-1:0]  ctl_rdata,
   output logic [DESC_WIDTH:0]    hdr_rdata,
   output logic [DESC_WIDTH-1:0]  dat_rdata
);
   import tpsq_pkg::*;

   logic [DESC_WIDTH-1:0] ctl_mem [CONTROL_DEPTH];
   logic [DESC_WIDTH:0]   hdr_mem [HEADER_DEPTH];
   logic [DESC_WIDTH-1:0] dat_mem [5 * DATA_DEPTH];

   // Write one entry, read the queue heads
   always_ff @(posedge clock) begin
      if (cmd.ctl_wr) ctl_mem[ctl_waddr] <= wr_desc;
      if (cmd.hdr_wr) hdr_mem[hdr_waddr] <= {wr_trim, wr_desc};
      if (cmd.dat_wr) dat_mem[dat_waddr] <= wr_desc;
      ctl_rdata <= ctl_mem[ctl_raddr];
      hdr_rdata <= hdr_mem[hdr_raddr];
      dat_rdata <= dat_mem[dat_raddr];
   end

endmodule

// File: design/trimming_priority_switch_queue_unit.sv
// Trimming priority switch queue unit: one item (push or pop) at a time. An
// item is taken in the idle state, the execute state latches the registered
// memory read into the result register, and the result is offered from the
// hold state that follows. Input stays stalled until the result leaves, so
// a new item is taken only once the last result is gone. Heads and counts
// sit in flip-flops; descriptors live in three synchronous memories. No
// clearing pass after reset.
module trimming_priority_switch_queue_unit #(
   parameter int DATA_DEPTH    = 64,
   parameter int HEADER_DEPTH  = 64,
   parameter int CONTROL_DEPTH = 16,
   parameter int DESC_WIDTH    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_descriptor,
   input  logic        req_syn_flag,
   input  logic        req_header_flag,
   input  logic        req_pull_flag,
   input  logic [2:0]  req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_push_outcome,
   output logic        rsp_pop_valid,
   output logic [15:0] rsp_pop_descriptor,
   output logic [1:0]  rsp_pop_source,
   output logic        rsp_pop_trimmed,
   output logic [2:0]  rsp_pop_class,
   output logic [15:0] rsp_trimmed_total,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tpsq_pkg::*;
   `include "trimming_priority_switch_queue_unit_assert.svh"

   localparam int CW = $clog2(CONTROL_DEPTH);
   localparam int HW = $clog2(HEADER_DEPTH);
   localparam int DW = $clog2(DATA_DEPTH);
   localparam int KW = $clog2(5 * DATA_DEPTH);
   localparam int CCW = $clog2(CONTROL_DEPTH + 1);
   localparam int HCW = $clog2(HEADER_DEPTH + 1);
   localparam int DCW = $clog2(DATA_DEPTH + 1);
   localparam int SW = $clog2(5 * DATA_DEPTH + 1);

   // Configuration registers
   logic [6:0] capacity_ff;
   logic [7:0] period_ff;
   logic       cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 7'd64;
         period_ff   <= 8'd10;
      end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
         capacity_ff <= pwdata[6:0];
      end else if (cfg_wr && paddr[2] == REG_PERIOD) begin
         period_ff <= pwdata[7:0];
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CAPACITY) prdata[6:0] = capacity_ff;
      else prdata[7:0] = period_ff;
   end

   // Queue state
   logic [CW-1:0]  ctl_head_ff;
   logic [CCW-1:0] ctl_count_ff;
   logic [HW-1:0]  hdr_head_ff;
   logic [HCW-1:0] hdr_count_ff;
   logic [DW-1:0]  cls_head_ff [NUM_CLASSES];
   logic [DCW-1:0] cls_count_ff [NUM_CLASSES];
   logic [SW-1:0]  shared_ff;
   logic [7:0]     turn_ff;
   logic [15:0]    trim_ff;

   state_type state_ff, state_in;
   logic accept;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   // Decode of the accepted item
   logic [DESC_WIDTH-1:0] desc;
   logic       is_pop;
   logic [2:0] prio;
   logic       cls_ok, cls_full, shared_full, trim_path;
   logic [DCW-1:0] cnt_sel;
   logic [DW-1:0]  head_sel;
   logic [2:0] outcome;
   mem_cmd_type cmd;
   logic       pop_any, pop_ctl, pop_hdr, pop_dat;
   logic [2:0] pop_cls;
   logic       contended;

   assign desc = req_descriptor[DESC_WIDTH-1:0];
   assign is_pop = (req_op == OP_POP);
   assign prio = req_priority_req;
   assign cls_ok = (prio < 3'd5);
   assign cnt_sel = cls_ok ? cls_count_ff[prio] : '0;
   assign head_sel = cls_ok ? cls_head_ff[prio] : '0;
   assign cls_full = (cnt_sel == DCW'(DATA_DEPTH));
   assign shared_full = (shared_ff >= SW'(capacity_ff));
   assign trim_path = shared_full || cls_full;

   // Strict class order 1,2,3,4,0
   always_comb begin
      pop_cls = 3'd0;
      if (cls_count_ff[1] != 0) pop_cls = 3'd1;
      else if (cls_count_ff[2] != 0) pop_cls = 3'd2;
      else if (cls_count_ff[3] != 0) pop_cls = 3'd3;
      else if (cls_count_ff[4] != 0) pop_cls = 3'd4;
   end

   assign contended = (hdr_count_ff != 0) && (shared_ff != 0);
   always_comb begin
      pop_ctl = ctl_count_ff != 0;
      pop_hdr = 1'b0;
      pop_dat = 1'b0;
      if (!pop_ctl) begin
         if (contended) begin
            pop_dat = (turn_ff == 8'd0);
            pop_hdr = !pop_dat;
         end else begin
            pop_dat = shared_ff != 0;
            pop_hdr = hdr_count_ff != 0;
         end
      end
      pop_any = pop_ctl || pop_hdr || pop_dat;
   end

   always_comb begin
      cmd = '0;
      outcome = OUT_CTL_QUEUED;
      if (req_syn_flag) begin
         if (ctl_count_ff == CCW'(CONTROL_DEPTH)) outcome = OUT_CTL_OVERFLOW;
         else cmd.ctl_wr = 1'b1;
      end else if (req_header_flag || req_pull_flag) begin
         if (hdr_count_ff == HCW'(HEADER_DEPTH)) outcome = OUT_DROPPED;
         else begin
            cmd.hdr_wr = 1'b1;
            outcome = OUT_HDR_QUEUED;
         end
      end else if (!cls_ok) begin
         outcome = OUT_BAD_PRIO;
      end else if (trim_path) begin
         if (prio == 3'd1 || hdr_count_ff == HCW'(HEADER_DEPTH)) outcome = OUT_DROPPED;
         else begin
            cmd.hdr_wr = 1'b1;
            outcome = OUT_TRIMMED;
         end
      end else begin
         cmd.dat_wr = 1'b1;
         outcome = OUT_DATA_QUEUED;
      end
      if (!(accept && !is_pop)) cmd = '0;
   end

   // Addresses
   logic [CW-1:0] ctl_waddr;
   logic [HW-1:0] hdr_waddr;
   logic [KW-1:0] dat_waddr, dat_raddr;
   logic [DW:0]   dsum;
   logic [CW:0]   csum;
   logic [HW:0]   hsum;
   assign csum = {1'b0, ctl_head_ff} + (CW + 1)'(ctl_count_ff);
   assign ctl_waddr = (csum >= (CW + 1)'(CONTROL_DEPTH)) ?
                      CW'(csum - (CW + 1)'(CONTROL_DEPTH)) : CW'(csum);
   assign hsum = {1'b0, hdr_head_ff} + (HW + 1)'(hdr_count_ff);
   assign hdr_waddr = (hsum >= (HW + 1)'(HEADER_DEPTH)) ?
                      HW'(hsum - (HW + 1)'(HEADER_DEPTH)) : HW'(hsum);
   assign dsum = {1'b0, head_sel} + (DW + 1)'(cnt_sel);
   assign dat_waddr = KW'(prio) * KW'(DATA_DEPTH) +
      KW'((dsum >= (DW + 1)'(DATA_DEPTH)) ? dsum - (DW + 1)'(DATA_DEPTH) : dsum);
   assign dat_raddr = KW'(pop_cls) * KW'(DATA_DEPTH) + KW'(cls_head_ff[pop_cls]);

   logic [DESC_WIDTH-1:0] ctl_rdata, dat_rdata;
   logic [DESC_WIDTH:0]   hdr_rdata;

   tpsq_store #(
      .DATA_DEPTH(DATA_DEPTH), .HEADER_DEPTH(HEADER_DEPTH),
      .CONTROL_DEPTH(CONTROL_DEPTH), .DESC_WIDTH(DESC_WIDTH)
   ) u_store (
      .clock(clock), .cmd(cmd), .wr_desc(desc), .wr_trim(!req_header_flag &&
         !req_pull_flag), .ctl_waddr(ctl_waddr), .hdr_waddr(hdr_waddr),
      .dat_waddr(dat_waddr), .ctl_raddr(ctl_head_ff), .hdr_raddr(hdr_head_ff),
      .dat_raddr(dat_raddr), .ctl_rdata(ctl_rdata), .hdr_rdata(hdr_rdata),
      .dat_rdata(dat_rdata)
   );

   // Bookkeeping update on accept
   logic [7:0] period_eff;
   assign period_eff = (period_ff == 8'd0) ? 8'd1 : period_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_head_ff <= '0; ctl_count_ff <= '0;
         hdr_head_ff <= '0; hdr_count_ff <= '0;
         shared_ff <= '0; turn_ff <= '0; trim_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cls_head_ff[i] <= '0;
            cls_count_ff[i] <= '0;
         end
      end else if (accept) begin
         if (!is_pop) begin
            if (cmd.ctl_wr) ctl_count_ff <= ctl_count_ff + 1'b1;
            if (cmd.hdr_wr) hdr_count_ff <= hdr_count_ff + 1'b1;
            if (outcome == OUT_TRIMMED) trim_ff <= trim_ff + 16'd1;
            if (cmd.dat_wr) begin
               cls_count_ff[prio] <= cls_count_ff[prio] + 1'b1;
               shared_ff <= shared_ff + 1'b1;
            end
         end else begin
            if (pop_ctl) begin
               ctl_head_ff <= (ctl_head_ff == CW'(CONTROL_DEPTH - 1)) ? '0 :
                              ctl_head_ff + 1'b1;
               ctl_count_ff <= ctl_count_ff - 1'b1;
            end
            if (pop_hdr) begin
               hdr_head_ff <= (hdr_head_ff == HW'(HEADER_DEPTH - 1)) ? '0 :
                              hdr_head_ff + 1'b1;
               hdr_count_ff <= hdr_count_ff - 1'b1;
            end
            if (pop_dat) begin
               cls_head_ff[pop_cls] <= (cls_head_ff[pop_cls] == DW'(DATA_DEPTH - 1)) ?
                                       '0 : cls_head_ff[pop_cls] + 1'b1;
               cls_count_ff[pop_cls] <= cls_count_ff[pop_cls] - 1'b1;
               shared_ff <= shared_ff - 1'b1;
            end
            if (!pop_ctl && contended)
               turn_ff <= (turn_ff + 8'd1 >= period_eff) ? 8'd0 : turn_ff + 8'd1;
         end
      end
   end

   // Result staging: capture decisions on accept, then read data in the execute state
   logic [2:0] outcome_ff;
   logic [1:0] src_ff;
   logic       pvalid_ff;
   logic [2:0] pcls_ff;
   logic       is_pop_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         is_pop_ff  <= is_pop;
         outcome_ff <= is_pop ? OUT_CTL_QUEUED : outcome;
         pvalid_ff  <= is_pop && pop_any;
         src_ff     <= pop_ctl ? SRC_CONTROL : (pop_hdr ? SRC_HEADER : SRC_DATA);
         pcls_ff    <= pop_cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_HOLD;
         ST_HOLD: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register, loaded when the memory read returns
   logic [15:0] pdesc_ff;
   logic        ptrim_ff;
   logic [1:0]  rsrc_ff;
   logic [2:0]  rcls_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         pdesc_ff <= '0; ptrim_ff <= 1'b0; rsrc_ff <= '0; rcls_ff <= '0;
         if (pvalid_ff) begin
            rsrc_ff <= src_ff;
            unique case (src_ff)
               SRC_CONTROL: pdesc_ff <= 16'(ctl_rdata);
               SRC_HEADER: begin
                  pdesc_ff <= 16'(hdr_rdata[DESC_WIDTH-1:0]);
                  ptrim_ff <= hdr_rdata[DESC_WIDTH];
               end
               default: begin
                  pdesc_ff <= 16'(dat_rdata);
                  rcls_ff <= pcls_ff;
               end
            endcase
         end
      end
   end

   assign rsp_valid = (state_ff == ST_HOLD);
   assign rsp_push_outcome = outcome_ff;
   assign rsp_pop_valid = pvalid_ff;
   assign rsp_pop_descriptor = pdesc_ff;
   assign rsp_pop_source = rsrc_ff;
   assign rsp_pop_trimmed = ptrim_ff;
   assign rsp_pop_class = rcls_ff;
   assign rsp_trimmed_total = trim_ff;

   `TPSQ_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !accept, "accept while busy")
   `TPSQ_ASSERT_IMP(a_pop_has_no_outcome, clock, reset, rsp_valid && is_pop_ff, rsp_push_outcome == OUT_CTL_QUEUED, "pop with outcome")
   `TPSQ_ASSERT_IMP(a_push_no_pop, clock, reset, rsp_valid && !is_pop_ff, !rsp_pop_valid, "push shows pop")
   `TPSQ_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC, "exec not entered")

endmodule

// File: tb/sv/tb.sv
// Testbench for the trimming priority switch queue unit: directed and random
// pushes and pops checked against a local model of the queues. Depends on tpsq_pkg.
module tb;
   import tpsq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DDEPTH = 64;
   localparam int HDEPTH = 64;
   localparam int CDEPTH = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_PUSH;
   logic [15:0] req_descriptor = '0;
   logic        req_syn_flag = 1'b0;
   logic        req_header_flag = 1'b0;
   logic        req_pull_flag = 1'b0;
   logic [2:0]  req_priority_req = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_push_outcome;
   logic        rsp_pop_valid;
   logic [15:0] rsp_pop_descriptor;
   logic [1:0]  rsp_pop_source;
   logic        rsp_pop_trimmed;
   logic [2:0]  rsp_pop_class;
   logic [15:0] rsp_trimmed_total;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   trimming_priority_switch_queue_unit dut (.*);

   typedef struct packed {
      logic [2:0]  outcome;
      logic        pvalid;
      logic [15:0] pdesc;
      logic [1:0]  psrc;
      logic        ptrim;
      logic [2:0]  pclass;
      logic [15:0] total;
   } queue_result_type;

   // Model state
   logic [15:0] ctl_q[$];
   logic [16:0] hdr_q[$];
   logic [15:0] cls_q[NUM_CLASSES][$];
   int unsigned turn_cnt;
   logic [15:0] trim_cnt;
   logic [6:0]  capacity;
   logic [7:0]  period;

   queue_result_type expected_results[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int pops_served = 0;

   initial forever #5 clock = ~clock;

   function automatic int shared_fill();
      int s = 0;
      for (int i = 0; i < NUM_CLASSES; i++) s += cls_q[i].size();
      return s;
   endfunction

   function automatic void take_data(ref queue_result_type r);
      int order[NUM_CLASSES] = '{1, 2, 3, 4, 0};
      int c;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         c = order[i];
         if (cls_q[c].size() != 0) begin
            r.pvalid = 1'b1;
            r.pdesc = cls_q[c].pop_front();
            r.psrc = SRC_DATA;
            r.pclass = 3'(c);
            return;
         end
      end
   endfunction

   function automatic void take_header(ref queue_result_type r);
      logic [16:0] e;
      e = hdr_q.pop_front();
      r.pvalid = 1'b1;
      r.pdesc = e[15:0];
      r.psrc = SRC_HEADER;
      r.ptrim = e[16];
   endfunction

   // Work out the result of one item and advance the model
   function automatic queue_result_type predict_queue(logic op, logic [15:0] d, logic syn,
         logic hdr, logic pull, logic [2:0] prio);
      queue_result_type r;
      int sh;
      int per;
      r = '0;
      sh = shared_fill();
      if (op == OP_PUSH) begin
         if (syn) begin
            if (ctl_q.size() >= CDEPTH) r.outcome = OUT_CTL_OVERFLOW;
            else begin ctl_q.push_back(d); r.outcome = OUT_CTL_QUEUED; end
         end else if (hdr || pull) begin
            if (hdr_q.size() >= HDEPTH) r.outcome = OUT_DROPPED;
            else begin hdr_q.push_back({1'b0, d}); r.outcome = OUT_HDR_QUEUED; end
         end else if (prio >= NUM_CLASSES) begin
            r.outcome = OUT_BAD_PRIO;
         end else if (sh >= capacity || cls_q[prio].size() >= DDEPTH) begin
            if (prio == 1 || hdr_q.size() >= HDEPTH) r.outcome = OUT_DROPPED;
            else begin
               hdr_q.push_back({1'b1, d});
               trim_cnt++;
               r.outcome = OUT_TRIMMED;
            end
         end else begin
            cls_q[prio].push_back(d);
            r.outcome = OUT_DATA_QUEUED;
         end
      end else begin
         if (ctl_q.size() != 0) begin
            r.pvalid = 1'b1;
            r.pdesc = ctl_q.pop_front();
            r.psrc = SRC_CONTROL;
         end else if (hdr_q.size() == 0 && sh != 0) take_data(r);
         else if (hdr_q.size() != 0 && sh == 0) take_header(r);
         else if (hdr_q.size() != 0) begin
            per = (period == 0) ? 1 : period;
            if (turn_cnt == 0) take_data(r);
            else take_header(r);
            turn_cnt = (turn_cnt + 1 >= per) ? 0 : turn_cnt + 1;
         end
      end
      r.total = trim_cnt;
      return r;
   endfunction

   // Send one item and queue its expected result; valid stays high for a
   // following item and drops only while idling or draining
   task automatic send_item(logic op, logic [15:0] d, logic syn, logic hdr, logic pull,
         logic [2:0] prio);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_descriptor <= d;
      req_syn_flag <= syn;
      req_header_flag <= hdr;
      req_pull_flag <= pull;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_queue(op, d, syn, hdr, pull, prio));
      items_sent++;
   endtask

   task automatic push_item(logic [15:0] d, logic syn, logic hdr, logic pull,
         logic [2:0] prio);
      send_item(OP_PUSH, d, syn, hdr, pull, prio);
   endtask

   task automatic pop_item();
      send_item(OP_POP, 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
         3'($urandom));
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write over the configuration port, block idle
   task automatic write_reg(logic idx, logic [31:0] v);
      drain_wait();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_CAPACITY) capacity = v[6:0];
      else period = v[7:0];
   endtask

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      queue_result_type got, exp_r;
      if (!reset) rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_push_outcome, rsp_pop_valid, rsp_pop_descriptor, rsp_pop_source,
                rsp_pop_trimmed, rsp_pop_class, rsp_trimmed_total};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            exp_r = expected_results.pop_front();
            if (exp_r.pvalid) pops_served++;
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h got %h (out %0d/%0d desc %h/%h src %0d/%0d)",
                     exp_r, got, exp_r.outcome, got.outcome, exp_r.pdesc, got.pdesc,
                     exp_r.psrc, got.psrc);
            end
         end
      end
   end

   // Control, header and pull pushes, data pushes at every priority code, then pops
   task automatic test_classes();
      push_item(16'hFFFF, 1, 1, 1, 7);
      push_item(16'h0000, 0, 1, 0, 0);
      push_item(16'hA5A5, 0, 0, 1, 3);
      for (int p = 0; p < 8; p++) push_item(16'(16'h1000 + p), 0, 0, 0, 3'(p));
      repeat (12) pop_item();
   endtask

   // Fill the control queue past its depth, then empty it
   task automatic test_control_overflow();
      for (int i = 0; i < CDEPTH + 2; i++) push_item(16'($urandom), 1, 0, 0, 0);
      repeat (CDEPTH + 1) pop_item();
   endtask

   // Zero capacity trims everything but class 1, which is dropped
   task automatic test_trimming();
      write_reg(REG_CAPACITY, 0);
      for (int i = 0; i < HDEPTH + 3; i++) push_item(16'($urandom), 0, 0, 0, 3'(i % 5));
      push_item(16'h7777, 0, 1, 0, 0);
      repeat (HDEPTH + 1) pop_item();
      write_reg(REG_CAPACITY, 64);
   endtask

   // Contended pops under several turn periods
   task automatic test_turns(logic [7:0] per);
      write_reg(REG_PERIOD, per);
      for (int i = 0; i < 30; i++) push_item(16'($urandom), 0, 1'($urandom), 0, 3'(i % 5));
      repeat (31) pop_item();
   endtask

   // Random mix, mostly well-formed, pressure on the data queues
   task automatic test_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 45) pop_item();
         else if (k < 55) push_item(16'($urandom), 1'($urandom_range(9) == 0), 1'($urandom),
                                    1'($urandom), 3'($urandom));
         else push_item(16'($urandom), 1'($urandom_range(19) == 0), 1'($urandom_range(9) == 0),
                        1'($urandom_range(9) == 0), 3'($urandom_range(5) == 0 ?
                        $urandom_range(7) : $urandom_range(4)));
      end
   endtask

   initial begin
      capacity = 64;
      period = 10;
      turn_cnt = 0;
      trim_cnt = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_classes();
      test_control_overflow();
      test_trimming();
      test_turns(0);
      test_turns(1);
      test_turns(255);
      test_turns(3);
      write_reg(REG_CAPACITY, 7'd127);
      test_random(65);
      write_reg(REG_CAPACITY, 7'd20);
      send_idle_pct = 26;
      recv_idle_pct = 69;
      test_random(150);
      drain_wait();
      write_reg(REG_CAPACITY, 7'd64);
      write_reg(REG_PERIOD, 8'd4);
      send_idle_pct = 69;
      recv_idle_pct = 26;
      test_random(150);
      write_reg(REG_CAPACITY, 7'd5);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(150);
      drain_wait();
      repeat (10) @(posedge clock);
      $display("covered %0d items (%0d descriptors popped), trims counted %0d",
         items_sent, pops_served, trim_cnt);
      $display("capacities 0..127, turn periods 0..255, all idle patterns");
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
            expected_results.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard limit on run time
   initial begin
      #2ms;
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// File: sim.f
+incdir+design
design/tpsq_pkg.sv
design/tpsq_store.sv
design/trimming_priority_switch_queue_unit.sv
tb/sv/tb.sv
